[rtl/jss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jss_pkg
// Shared types and codes of the JTAG scan sequencer.
// ----------------------------------------------------------------------------
package jss_pkg;

	// Command codes carried in the func field.
	localparam logic [2:0] FUNC_TICK     = 3'd0;
	localparam logic [2:0] FUNC_RESET    = 3'd1;
	localparam logic [2:0] FUNC_RUN_TEST = 3'd2;
	localparam logic [2:0] FUNC_SHIFT_IR = 3'd3;
	localparam logic [2:0] FUNC_SHIFT_DR = 3'd4;
	localparam logic [2:0] FUNC_RAW      = 3'd5;

	// Loaded operation kinds; these share the encoding of the load commands.
	localparam logic [2:0] OP_IDLE     = 3'd0;
	localparam logic [2:0] OP_RESET    = 3'd1;
	localparam logic [2:0] OP_RUN_TEST = 3'd2;
	localparam logic [2:0] OP_SHIFT_IR = 3'd3;
	localparam logic [2:0] OP_SHIFT_DR = 3'd4;

	// Scan phases.
	localparam logic [1:0] PH_PRE  = 2'd0;
	localparam logic [1:0] PH_BODY = 2'd1;
	localparam logic [1:0] PH_POST = 2'd2;

	// Number of TMS-high cycles of a TAP reset.
	localparam logic [6:0] RESET_HIGH_CYCLES = 7'd6;

	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] bit_count;
		logic [63:0] shift_data;
		logic        tdo_bit;
		logic        tms_bit;
		logic        tdi_bit;
	} cmd_t;

	typedef struct packed {
		logic        tck_pulse;
		logic        tms_out;
		logic        tdi_out;
		logic [63:0] captured_data;
		logic        op_done;
		logic        seq_busy;
	} rsp_t;

	typedef struct packed {
		logic [2:0]  op_kind;
		logic [1:0]  phase;
		logic [6:0]  step_count;
		logic [15:0] bits_left;
		logic [63:0] out_shifter;
		logic [63:0] capture_word;
	} seq_state_t;

endpackage : jss_pkg
`default_nettype wire

[rtl/jss_cmd_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jss_cmd_if
// Command channel of the JTAG scan sequencer: valid/ready plus one request.
// ----------------------------------------------------------------------------
interface jss_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [15:0] bit_count;
	logic [63:0] shift_data;
	logic        tdo_bit;
	logic        tms_bit;
	logic        tdi_bit;

	modport source (
		output valid, func, bit_count, shift_data, tdo_bit, tms_bit, tdi_bit,
		input  ready
	);
	modport sink (
		input  valid, func, bit_count, shift_data, tdo_bit, tms_bit, tdi_bit,
		output ready
	);
endinterface : jss_cmd_if
`default_nettype wire

[rtl/jss_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jss_rsp_if
// Result channel of the JTAG scan sequencer: valid/ready plus one result.
// ----------------------------------------------------------------------------
interface jss_rsp_if;
	logic        valid;
	logic        ready;
	logic        tck_pulse;
	logic        tms_out;
	logic        tdi_out;
	logic [63:0] captured_data;
	logic        op_done;
	logic        seq_busy;

	modport source (
		output valid, tck_pulse, tms_out, tdi_out, captured_data, op_done, seq_busy,
		input  ready
	);
	modport sink (
		input  valid, tck_pulse, tms_out, tdi_out, captured_data, op_done, seq_busy,
		output ready
	);
endinterface : jss_rsp_if
`default_nettype wire

[rtl/jss_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jss_step
// Next-state and result logic for one command of the sequencer.
// ----------------------------------------------------------------------------
module jss_step
	import jss_pkg::*;
#(
	parameter int MAX_DR_BITS = 64,
	parameter int MAX_IR_BITS = 32
) (
	input  var seq_state_t st,
	input  var cmd_t       cmd,
	input  wire            drive_en,
	output seq_state_t     nxt,
	output logic           rsp_valid,
	output rsp_t           rsp
);

	localparam logic [15:0] IR_LIMIT = 16'(MAX_IR_BITS);
	localparam logic [15:0] DR_LIMIT = 16'(MAX_DR_BITS);

	always_comb begin
		logic        done;
		logic        is_ir;
		logic        pre_last;
		logic [15:0] count;

		nxt       = st;
		rsp_valid = 1'b0;
		rsp       = '0;
		done      = 1'b0;
		is_ir     = (st.op_kind == OP_SHIFT_IR);
		pre_last  = 1'b0;
		count     = cmd.bit_count;

		case (cmd.func) inside
			FUNC_TICK: begin
				if (st.op_kind != OP_IDLE) begin
					rsp_valid = 1'b1;
					if (!drive_en) begin
						// Pins released: report only, the operation holds.
						rsp.seq_busy = 1'b1;
						if (st.op_kind == OP_SHIFT_IR || st.op_kind == OP_SHIFT_DR) begin
							rsp.captured_data = st.capture_word;
						end
					end else begin
						rsp.tck_pulse = 1'b1;
						case (st.op_kind)
							OP_RESET: begin
								if (st.step_count < RESET_HIGH_CYCLES) begin
									rsp.tms_out    = 1'b1;
									nxt.step_count = st.step_count + 7'd1;
								end else begin
									done = 1'b1;
								end
							end
							OP_RUN_TEST: begin
								nxt.bits_left = st.bits_left - 16'd1;
								done          = (st.bits_left == 16'd1);
							end
							default: begin
								case (st.phase)
									PH_PRE: begin
										if (is_ir) begin
											rsp.tms_out = (st.step_count < 7'd2);
											pre_last    = (st.step_count == 7'd3);
										end else begin
											rsp.tms_out = (st.step_count < 7'd1);
											pre_last    = (st.step_count == 7'd2);
										end
										if (pre_last) begin
											nxt.step_count = '0;
											nxt.phase = (st.bits_left == 16'd0) ? PH_POST : PH_BODY;
										end else begin
											nxt.step_count = st.step_count + 7'd1;
										end
									end
									PH_BODY: begin
										rsp.tdi_out = st.out_shifter[0];
										rsp.tms_out = (st.bits_left == 16'd1);
										if (cmd.tdo_bit) begin
											nxt.capture_word[st.step_count[5:0]] = 1'b1;
										end
										nxt.out_shifter = {1'b0, st.out_shifter[63:1]};
										nxt.bits_left   = st.bits_left - 16'd1;
										if (st.bits_left == 16'd1) begin
											nxt.phase      = PH_POST;
											nxt.step_count = '0;
										end else begin
											nxt.step_count = st.step_count + 7'd1;
										end
									end
									default: begin
										rsp.tms_out = (st.step_count == 7'd0);
										if (st.step_count == 7'd0) begin
											nxt.step_count = 7'd1;
										end else begin
											done = 1'b1;
										end
									end
								endcase
								rsp.captured_data = nxt.capture_word;
							end
						endcase
						rsp.op_done = done;
						if (done) begin
							nxt.op_kind    = OP_IDLE;
							nxt.phase      = PH_PRE;
							nxt.step_count = '0;
							nxt.bits_left  = '0;
						end
						rsp.seq_busy = (nxt.op_kind != OP_IDLE);
					end
				end
			end
			FUNC_RESET, FUNC_RUN_TEST, FUNC_SHIFT_IR, FUNC_SHIFT_DR: begin
				if (cmd.func == FUNC_SHIFT_IR && count > IR_LIMIT) begin
					count = IR_LIMIT;
				end
				if (cmd.func == FUNC_SHIFT_DR && count > DR_LIMIT) begin
					count = DR_LIMIT;
				end
				nxt.op_kind      = cmd.func;
				nxt.phase        = PH_PRE;
				nxt.step_count   = '0;
				nxt.bits_left    = count;
				nxt.out_shifter  = cmd.shift_data;
				nxt.capture_word = '0;
				// A run-test with a bit_count of zero has nothing to do.
				if (cmd.func == FUNC_RUN_TEST && count == 16'd0) begin
					nxt.op_kind = OP_IDLE;
				end
			end
			FUNC_RAW: begin
				rsp_valid    = 1'b1;
				rsp.seq_busy = (st.op_kind != OP_IDLE);
				if (drive_en) begin
					rsp.tck_pulse     = 1'b1;
					rsp.tms_out       = cmd.tms_bit;
					rsp.tdi_out       = cmd.tdi_bit;
					rsp.captured_data = {63'd0, cmd.tdo_bit};
					rsp.op_done       = 1'b1;
				end
			end
			default: begin
				rsp_valid = 1'b0;
			end
		endcase
	end

endmodule : jss_step
`default_nettype wire

[rtl/jtag_scan_sequencer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jtag_scan_sequencer_unit
// Host-side JTAG TAP sequencer: loads reset, run-test and IR/DR scans, plays
// them one TCK cycle per tick request while drive_enable is set, and drives raw cycles.
//
//   channel | dir | handshake        | content
//   cmd     | in  | valid/ready      | func, bit_count, shift_data, tdo/tms/tdi
//   rsp     | out | valid/ready      | pin levels, capture word, done, busy
//   cfg     | in  | cfg_we, no ready | drive_enable in cfg_wdata
//
// One request is accepted per clock while cmd.ready is high. An accepted
// request sits in the input register; its result is loaded into the result
// register once that register is empty or being taken by rsp.ready.
// Commands that load an operation, ticks while idle and unknown codes
// produce no result. A stalled result holds the result register and, once
// the input register is also full, cmd.ready drops.
// arst_n clears the sequencer to idle and drive_enable to zero.
// ----------------------------------------------------------------------------
module jtag_scan_sequencer_unit
	import jss_pkg::*;
#(
	parameter int MAX_DR_BITS = 64,
	parameter int MAX_IR_BITS = 32
) (
	input  wire        clk,
	input  wire        arst_n,
	jss_cmd_if.sink    cmd,
	jss_rsp_if.source  rsp,
	input  wire        cfg_we,
	input  wire        cfg_wdata
);

	logic       drive_enable_q;
	logic       valid_s1;
	cmd_t       cmd_s1;
	logic       valid_s2;
	rsp_t       rsp_s2;
	seq_state_t state_q;
	seq_state_t state_nxt;
	logic       step_valid;
	rsp_t       step_rsp;
	logic       adv_s2;
	logic       take_s1;

	assign adv_s2    = !valid_s2 || rsp.ready;
	assign take_s1   = valid_s1 && adv_s2;
	assign cmd.ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_enable_q <= 1'b0;
		end else if (cfg_we) begin
			drive_enable_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1.func       <= cmd.func;
			cmd_s1.bit_count  <= cmd.bit_count;
			cmd_s1.shift_data <= cmd.shift_data;
			cmd_s1.tdo_bit    <= cmd.tdo_bit;
			cmd_s1.tms_bit    <= cmd.tms_bit;
			cmd_s1.tdi_bit    <= cmd.tdi_bit;
		end
	end

	jss_step #(
		.MAX_DR_BITS (MAX_DR_BITS),
		.MAX_IR_BITS (MAX_IR_BITS)
	) u_step (
		.st        (state_q),
		.cmd       (cmd_s1),
		.drive_en  (drive_enable_q),
		.nxt       (state_nxt),
		.rsp_valid (step_valid),
		.rsp       (step_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= take_s1 && step_valid;
			if (take_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && step_valid) begin
			rsp_s2 <= step_rsp;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.tck_pulse     = rsp_s2.tck_pulse;
	assign rsp.tms_out       = rsp_s2.tms_out;
	assign rsp.tdi_out       = rsp_s2.tdi_out;
	assign rsp.captured_data = rsp_s2.captured_data;
	assign rsp.op_done       = rsp_s2.op_done;
	assign rsp.seq_busy      = rsp_s2.seq_busy;

	// The idle state always carries a cleared position.
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.op_kind == OP_IDLE |->
			(state_q.phase == PH_PRE && state_q.step_count == '0 && state_q.bits_left == '0))
		else $error("idle sequencer with stale position");

	// A loaded run-test always has cycles left.
	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.op_kind == OP_RUN_TEST |-> state_q.bits_left != '0)
		else $error("run-test with zero cycles left");

	// The scan body is entered only with bits still to shift.
	a_body_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_BODY |-> state_q.bits_left != '0)
		else $error("scan body with no bits left");

	// A result without a TCK pulse never reports pin activity or completion.
	a_released_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !rsp_s2.tck_pulse |->
			(!rsp_s2.op_done && !rsp_s2.tms_out && !rsp_s2.tdi_out))
		else $error("released result shows pin activity");

endmodule : jtag_scan_sequencer_unit
`default_nettype wire
